>>> rtl/ordered_list_engine_core_assert.svh
// Assertion macros for the ordered list engine
`ifndef ORDERED_LIST_ENGINE_CORE_ASSERT_SVH
`define ORDERED_LIST_ENGINE_CORE_ASSERT_SVH

// implication checked on every edge outside reset
`define OLE_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// next-cycle implication
`define OLE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

>>> rtl/ole_pkg.sv
// ----------------------------------------------------------------------------
// ole_pkg
// Types and constants shared by the ordered list engine.
// ----------------------------------------------------------------------------
package ole_pkg;

	localparam int DepthDefault = 64;
	localparam int ValueWidthDefault = 32;

	localparam logic [2:0] OP_PUSH_BACK = 3'd0;
	localparam logic [2:0] OP_PUSH_FRONT = 3'd1;
	localparam logic [2:0] OP_POP_BACK = 3'd2;
	localparam logic [2:0] OP_POP_FRONT = 3'd3;
	localparam logic [2:0] OP_DELETE = 3'd4;
	localparam logic [2:0] OP_INSERT = 3'd5;
	localparam logic [2:0] OP_CLEAR = 3'd6;
	localparam logic [2:0] OP_QUERY = 3'd7;

	typedef struct packed {
		logic [2:0] kind;
		logic signed [31:0] item_value;
		logic [6:0] position;
	} ole_in_t;

	typedef struct packed {
		logic ok;
		logic [6:0] element_count;
		logic signed [31:0] last_value;
		logic last_valid;
		logic signed [31:0] max_value;
		logic max_valid;
	} ole_out_t;

endpackage

>>> rtl/ole_pool.sv
// ----------------------------------------------------------------------------
// ole_pool
// Node memory: a value array and a link array, one write and one read port,
// registered read data.
// ----------------------------------------------------------------------------
module ole_pool
	import ole_pkg::*;
#(
	parameter int DEPTH = DepthDefault,
	parameter int VALUE_WIDTH = ValueWidthDefault,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input logic clk,
	input logic we_v,
	input logic we_l,
	input logic [AW-1:0] waddr,
	input logic [VALUE_WIDTH-1:0] wvalue,
	input logic [AW-1:0] wlink,
	input logic [AW-1:0] raddr,
	output logic [VALUE_WIDTH-1:0] rvalue,
	output logic [AW-1:0] rlink
);
	logic [VALUE_WIDTH-1:0] val_mem [DEPTH];
	logic [AW-1:0] link_mem [DEPTH];
	logic [VALUE_WIDTH-1:0] rvalue_q;
	logic [AW-1:0] rlink_q;

	// read returns the contents before a write in the same cycle
	always_ff @(posedge clk) begin
		if (we_v) begin
			val_mem[waddr] <= wvalue;
		end
		if (we_l) begin
			link_mem[waddr] <= wlink;
		end
		rvalue_q <= val_mem[raddr];
		rlink_q <= link_mem[raddr];
	end

	assign rvalue = rvalue_q;
	assign rlink = rlink_q;
endmodule

>>> rtl/ole_alloc.sv
// ----------------------------------------------------------------------------
// ole_alloc
// Free map with lowest-index-first allocation by a priority pick.
// ----------------------------------------------------------------------------
module ole_alloc
	import ole_pkg::*;
#(
	parameter int DEPTH = DepthDefault,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input logic clk,
	input logic arst_n,
	input logic take,
	input logic give,
	input logic [AW-1:0] give_idx,
	input logic clear_all,
	output logic [AW-1:0] free_idx
);
	logic [DEPTH-1:0] free_q;
	logic [DEPTH-1:0] free_d;

	// lowest free node; only meaningful while some node is free
	always_comb begin
		free_idx = '0;
		for (int i = DEPTH - 1; i >= 0; i--) begin
			if (free_q[i]) free_idx = AW'(i);
		end
	end

	always_comb begin
		free_d = free_q;
		if (take) free_d[free_idx] = 1'b0;
		if (give) free_d[give_idx] = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			free_q <= '1;
		end else if (clear_all) begin
			free_q <= '1;
		end else begin
			free_q <= free_d;
		end
	end
endmodule

>>> rtl/ordered_list_engine_core.sv
// ----------------------------------------------------------------------------
// ordered_list_engine_core
// Bounded singly linked list of signed values in a node pool.
// ----------------------------------------------------------------------------
// One operation per input beat, one result beat each, one item at a time:
// in_ready is high only while idle and returns the cycle after the result
// beat. The list is walked one node per cycle through the node memory's
// registered read port, first for the operation (pop front reads the head;
// pop back, delete and insert after walk toward their node) and then once
// over the whole list for the maximum and tail value. Nodes are allocated
// lowest free index first.
`include "ordered_list_engine_core_assert.svh"

module ordered_list_engine_core
	import ole_pkg::*;
#(
	parameter int DEPTH = DepthDefault,
	parameter int VALUE_WIDTH = ValueWidthDefault
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input ole_in_t in_data,
	output logic out_valid,
	input logic out_ready,
	output ole_out_t out_data
);
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	typedef enum logic [5:0] {
		ST_IDLE = 6'b000001,
		ST_WALK = 6'b000010,
		ST_LINK = 6'b000100,
		ST_MAXS = 6'b001000,
		ST_MAXW = 6'b010000,
		ST_OUT = 6'b100000
	} st_t;

	st_t st_q;
	logic [2:0] kind_q;
	logic [VALUE_WIDTH-1:0] val_q, mx_q;
	logic [6:0] pos_q;
	logic [AW-1:0] head_q, tail_q, cur_q, prev_q, new_q;
	logic [CW-1:0] cnt_q, step_q;
	logic ok_q;
	ole_out_t out_q;

	logic we_v, we_l;
	logic [AW-1:0] waddr, wlink, raddr, free_idx;
	logic [VALUE_WIDTH-1:0] wvalue, rvalue;
	logic [AW-1:0] rlink;
	logic take, give, clr;
	logic [AW-1:0] give_idx;

	ole_pool #(.DEPTH(DEPTH), .VALUE_WIDTH(VALUE_WIDTH)) u_pool (
		.clk, .we_v, .we_l, .waddr, .wvalue, .wlink, .raddr, .rvalue, .rlink
	);
	ole_alloc #(.DEPTH(DEPTH)) u_alloc (
		.clk, .arst_n, .take, .give, .give_idx, .clear_all(clr), .free_idx
	);

	logic [VALUE_WIDTH-1:0] in_v;
	assign in_v = VALUE_WIDTH'($signed(in_data.item_value));

	assign in_ready = (st_q == ST_IDLE);
	assign out_valid = (st_q == ST_OUT);
	assign out_data = out_q;

	logic start;
	assign start = in_valid && in_ready;
	logic full, empty;
	assign full = (cnt_q == CW'(DEPTH));
	assign empty = (cnt_q == '0);

	logic ins_bad, ins_hit;
	assign ins_bad = (in_data.position == 7'd0) ||
		(int'(in_data.position) > int'(cnt_q)) || full;
	// walk has reached the node after which insert places the new one
	assign ins_hit = (int'(step_q) + 1 == int'(pos_q));

	logic [VALUE_WIDTH-1:0] mx_next;
	assign mx_next = (step_q == '0 || $signed(rvalue) > $signed(mx_q)) ? rvalue : mx_q;

	// memory and allocator control
	always_comb begin
		we_v = 1'b0; we_l = 1'b0; waddr = '0; wvalue = '0; wlink = '0;
		raddr = head_q; take = 1'b0; give = 1'b0; give_idx = '0;
		clr = 1'b0;
		case (st_q)
		ST_IDLE: if (start) begin
			case (in_data.kind)
			OP_PUSH_BACK: if (!full) begin
				we_v = 1'b1; we_l = 1'b1; waddr = free_idx; wvalue = in_v;
				take = 1'b1;
			end
			OP_PUSH_FRONT: if (!full) begin
				we_v = 1'b1; we_l = 1'b1; waddr = free_idx; wvalue = in_v;
				wlink = head_q; take = 1'b1;
			end
			OP_CLEAR: clr = 1'b1;
			default: ;
			endcase
		end
		ST_WALK: begin
			// rvalue/rlink belong to cur_q; follow the link unless done
			raddr = rlink;
			case (kind_q)
			OP_POP_FRONT: begin
				give = 1'b1; give_idx = cur_q;
			end
			OP_POP_BACK: begin
				if (cnt_q == CW'(1)) begin
					give = 1'b1; give_idx = cur_q;
				end else if (step_q == cnt_q - CW'(2)) begin
					give = 1'b1; give_idx = tail_q;
					we_l = 1'b1; waddr = cur_q; wlink = '0;
				end
			end
			OP_DELETE: begin
				if (rvalue == val_q) begin
					give = 1'b1; give_idx = cur_q;
					if (step_q != '0) begin
						we_l = 1'b1; waddr = prev_q; wlink = rlink;
					end
				end
			end
			OP_INSERT: begin
				if (ins_hit) begin
					we_v = 1'b1; we_l = 1'b1; waddr = free_idx; wvalue = val_q;
					wlink = (cur_q == tail_q) ? '0 : rlink;
					take = 1'b1;
				end
			end
			default: ;
			endcase
		end
		ST_LINK: begin
			we_l = 1'b1; waddr = prev_q; wlink = new_q;
		end
		ST_MAXW: raddr = rlink;
		default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
			kind_q <= OP_QUERY; val_q <= '0; mx_q <= '0; pos_q <= '0;
			head_q <= '0; tail_q <= '0; cur_q <= '0; prev_q <= '0; new_q <= '0;
			cnt_q <= '0; step_q <= '0; ok_q <= 1'b0;
			out_q <= '0;
		end else begin
			case (st_q)
			ST_IDLE: if (start) begin
				kind_q <= in_data.kind; val_q <= in_v; pos_q <= in_data.position;
				cur_q <= head_q; step_q <= '0;
				case (in_data.kind)
				OP_PUSH_BACK: begin
					ok_q <= !full;
					if (!full) begin
						cnt_q <= cnt_q + CW'(1);
						tail_q <= free_idx; new_q <= free_idx; prev_q <= tail_q;
						if (empty) begin
							head_q <= free_idx; st_q <= ST_MAXS;
						end else st_q <= ST_LINK;
					end else st_q <= ST_MAXS;
				end
				OP_PUSH_FRONT: begin
					ok_q <= !full; st_q <= ST_MAXS;
					if (!full) begin
						cnt_q <= cnt_q + CW'(1); head_q <= free_idx;
						if (empty) tail_q <= free_idx;
					end
				end
				OP_POP_BACK, OP_POP_FRONT, OP_DELETE: begin
					ok_q <= 1'b0; prev_q <= '0;
					st_q <= empty ? ST_MAXS : ST_WALK;
				end
				OP_INSERT: begin
					ok_q <= 1'b0;
					st_q <= ins_bad ? ST_MAXS : ST_WALK;
				end
				OP_CLEAR: begin
					ok_q <= 1'b1; cnt_q <= '0; head_q <= '0; tail_q <= '0;
					st_q <= ST_MAXS;
				end
				OP_QUERY: begin
					ok_q <= 1'b1; st_q <= ST_MAXS;
				end
				default: ;
				endcase
			end
			ST_WALK: begin
				case (kind_q)
				OP_POP_FRONT: begin
					ok_q <= 1'b1; cnt_q <= cnt_q - CW'(1);
					if (cnt_q == CW'(1)) begin
						head_q <= '0; tail_q <= '0;
					end else head_q <= rlink;
					st_q <= ST_MAXS;
				end
				OP_POP_BACK: begin
					if (cnt_q == CW'(1)) begin
						ok_q <= 1'b1; cnt_q <= '0; head_q <= '0; tail_q <= '0;
						st_q <= ST_MAXS;
					end else if (step_q == cnt_q - CW'(2)) begin
						// cur_q is the node before the tail
						ok_q <= 1'b1; cnt_q <= cnt_q - CW'(1); tail_q <= cur_q;
						st_q <= ST_MAXS;
					end else begin
						cur_q <= rlink; step_q <= step_q + CW'(1);
					end
				end
				OP_DELETE: begin
					if (rvalue == val_q) begin
						ok_q <= 1'b1; cnt_q <= cnt_q - CW'(1); st_q <= ST_MAXS;
						if (cnt_q == CW'(1)) begin
							head_q <= '0; tail_q <= '0;
						end else begin
							if (step_q == '0) head_q <= rlink;
							if (cur_q == tail_q) tail_q <= prev_q;
						end
					end else if (step_q == cnt_q - CW'(1)) begin
						st_q <= ST_MAXS;
					end else begin
						prev_q <= cur_q; cur_q <= rlink; step_q <= step_q + CW'(1);
					end
				end
				OP_INSERT: begin
					if (ins_hit) begin
						// new node written now, its predecessor linked next cycle
						ok_q <= 1'b1; cnt_q <= cnt_q + CW'(1);
						new_q <= free_idx; prev_q <= cur_q;
						if (cur_q == tail_q) tail_q <= free_idx;
						st_q <= ST_LINK;
					end else begin
						cur_q <= rlink; step_q <= step_q + CW'(1);
					end
				end
				default: st_q <= ST_MAXS;
				endcase
			end
			ST_LINK: st_q <= ST_MAXS;
			ST_MAXS: begin
				// all writes of the item are done; the head read issues here
				step_q <= '0;
				if (empty) begin
					out_q <= '{ok: ok_q, element_count: 7'(cnt_q), last_value: '0,
						last_valid: 1'b0, max_value: '0, max_valid: 1'b0};
					st_q <= ST_OUT;
				end else st_q <= ST_MAXW;
			end
			ST_MAXW: begin
				if (step_q == cnt_q - CW'(1)) begin
					// last node walked is the tail
					out_q <= '{ok: ok_q, element_count: 7'(cnt_q),
						last_value: 32'($signed(rvalue)), last_valid: 1'b1,
						max_value: 32'($signed(mx_next)), max_valid: 1'b1};
					st_q <= ST_OUT;
				end else begin
					mx_q <= mx_next; step_q <= step_q + CW'(1);
				end
			end
			ST_OUT: if (out_ready) st_q <= ST_IDLE;
			default: st_q <= ST_IDLE;
			endcase
		end
	end

	`OLE_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(out_data))
	`OLE_ASSERT_IMP(a_one_side, clk, arst_n, out_valid, !in_ready)
	`OLE_ASSERT_IMP(a_count_range, clk, arst_n, 1'b1, cnt_q <= CW'(DEPTH))
	`OLE_ASSERT_IMP(a_empty_ends, clk, arst_n, empty, head_q == '0 && tail_q == '0)
	`OLE_ASSERT_IMP(a_take_room, clk, arst_n, take, !full)
endmodule
